@@ hdl/plbs_pkg.sv @@
// Package for the price ladder book side unit: sizes, codes, level record.
// No dependencies.
`default_nettype none
package plbs_pkg;
   localparam int LadderTicks = 4096;
   localparam int PoolSlots   = 16384;
   localparam int MapWords    = 64;
   localparam int TickW  = 12;
   localparam int SlotW  = 14;
   localparam int LinkW  = 15;
   localparam int LevelW = 13;
   localparam int WordW  = 6;
   localparam int TotalW = 48;
   localparam logic [LinkW-1:0] NullSlot = LinkW'(PoolSlots);
   localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

   localparam logic [1:0] ModeAdd = 2'd0;
   localparam logic [1:0] ModeRemove = 2'd1;
   localparam logic [1:0] ModeDecrement = 2'd2;
   localparam logic [1:0] ModeQuery = 2'd3;

   typedef struct packed {
      logic [LinkW-1:0]  head;
      logic [LinkW-1:0]  tail;
      logic [TotalW-1:0] total;
      logic [LinkW-1:0]  count;
   } level_type;
endpackage
`default_nettype wire

@@ hdl/plbs_req_if.sv @@
// Request and response channel interfaces.
// No dependencies.
`default_nettype none
interface plbs_req_if;
   logic valid;
   logic ready;
   logic [1:0] mode;
   logic side;
   logic [11:0] tick;
   logic [13:0] slot;
   logic [31:0] shares;
   modport source (output valid, mode, side, tick, slot, shares, input ready);
   modport sink (input valid, mode, side, tick, slot, shares, output ready);
endinterface

interface plbs_rsp_if;
   logic valid;
   logic ready;
   logic best_valid;
   logic [11:0] best_tick;
   logic [47:0] level_total;
   logic [14:0] level_orders;
   logic [14:0] level_first;
   logic level_drained;
   logic fault;
   modport source (output valid, best_valid, best_tick, level_total, level_orders,
                   level_first, level_drained, fault, input ready);
   modport sink (input valid, best_valid, best_tick, level_total, level_orders,
                 level_first, level_drained, fault, output ready);
endinterface
`default_nettype wire

@@ hdl/plbs_ram.sv @@
// Generic single-port-write, one-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module plbs_ram #(
   parameter int AddrW = 8,
   parameter int DataW = 8
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [DataW-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [DataW-1:0] rd_data
);
   logic [DataW-1:0] mem [2**AddrW];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ hdl/plbs_best_finder.sv @@
// Two-level bitmap search: word summary flags plus per-word priority encode.
// Depends on plbs_pkg and plbs_ram. Holds the occupancy words of both sides.
`default_nettype none
module plbs_best_finder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          clear,
   input  wire logic [plbs_pkg::WordW:0]      clr_addr,
   input  wire logic                          upd_en,
   input  wire logic                          upd_side,
   input  wire logic [plbs_pkg::TickW-1:0]    upd_tick,
   input  wire logic                          upd_set,
   input  wire logic                          scan_start,
   input  wire logic                          scan_side,
   output logic                               best_valid_ff [2],
   output logic      [plbs_pkg::TickW-1:0]    best_tick_ff [2]
);
   localparam int MW = plbs_pkg::WordW;
   localparam int AW = plbs_pkg::WordW + 1;
   logic [plbs_pkg::MapWords-1:0] sum_ff [2];
   // stage 1: pick word from summary flags
   logic          s1_ff, s1_side_ff, s1_any_ff;
   logic [MW-1:0] s1_word_ff;
   logic [MW-1:0] wsel_in;
   logic          any_in;
   logic [5:0]    bsel_in;
   logic [MW-1:0] upd_idx;
   logic [63:0]   map_rd, map_wd, upd_word;
   logic          map_we;
   logic [AW-1:0] map_wa, map_ra;

   assign upd_idx = upd_tick[plbs_pkg::TickW-1:6];

   // occupancy words, one per side and word index
   plbs_ram #(.AddrW(AW), .DataW(64)) u_map (
      .clock, .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
      .rd_addr(map_ra), .rd_data(map_rd));

   // read port: searched word while scanning, else the word being updated
   assign map_ra = scan_start ? {scan_side, wsel_in} : {upd_side, upd_idx};

   // read-modify-write of the addressed word; clearing sweep after reset
   assign upd_word = upd_set ? (map_rd | (64'd1 << upd_tick[5:0]))
                             : (map_rd & ~(64'd1 << upd_tick[5:0]));
   assign map_we = clear || upd_en;
   assign map_wa = clear ? clr_addr : {upd_side, upd_idx};
   assign map_wd = clear ? '0 : upd_word;

   // word select: highest for bids, lowest for asks
   always_comb begin
      any_in = |sum_ff[scan_side];
      wsel_in = '0;
      if (scan_side == 1'b0) begin
         for (int i = 0; i < plbs_pkg::MapWords; i++)
            if (sum_ff[scan_side][i]) wsel_in = MW'(i);
      end else begin
         for (int i = plbs_pkg::MapWords-1; i >= 0; i--)
            if (sum_ff[scan_side][i]) wsel_in = MW'(i);
      end
   end

   // bit select within the word read back from the map
   always_comb begin
      bsel_in = '0;
      if (s1_side_ff == 1'b0) begin
         for (int i = 0; i < 64; i++) if (map_rd[i]) bsel_in = 6'(i);
      end else begin
         for (int i = 63; i >= 0; i--) if (map_rd[i]) bsel_in = 6'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 2; s++) begin
            sum_ff[s] <= '0;
            best_valid_ff[s] <= 1'b0;
            best_tick_ff[s] <= '0;
         end
         s1_ff <= 1'b0;
      end else begin
         // summary flag follows the updated word
         if (upd_en) sum_ff[upd_side][upd_idx] <= |upd_word;
         s1_ff <= scan_start;
         if (scan_start) begin
            s1_side_ff <= scan_side;
            s1_word_ff <= wsel_in;
            s1_any_ff  <= any_in;
         end
         if (s1_ff) begin
            best_valid_ff[s1_side_ff] <= s1_any_ff;
            best_tick_ff[s1_side_ff]  <= s1_any_ff ? {s1_word_ff, bsel_in} : '0;
         end
      end
   end
endmodule
`default_nettype wire

@@ hdl/price_ladder_book_side_unit.sv @@
// Top level of the price ladder book side unit.
// Depends on plbs_pkg, plbs_req_if, plbs_ram, plbs_best_finder.
//
//  channel | dir | transfer when
//  req     | in  | req.valid && req.ready
//  rsp     | out | rsp.valid && rsp.ready
//
// One item at a time: request transfer in idle, read level, links and
// occupancy word, write back, bitmap search, then the result state, held
// until the result is taken. Reset is synchronous; level totals, counts
// and occupancy words are cleared by a sweep of all 8192 level addresses
// after reset, during which req.ready is low. A stalled result holds the
// unit in its output state.
`default_nettype none
module price_ladder_book_side_unit (
   input wire logic clock,
   input wire logic reset,
   plbs_req_if.sink   req,
   plbs_rsp_if.source rsp
);
   localparam int LW = plbs_pkg::LevelW;
   localparam int KW = plbs_pkg::LinkW;

   typedef enum logic [5:0] {
      StClear = 6'b000001, StIdle = 6'b000010, StRead = 6'b000100,
      StWrite = 6'b001000, StScan = 6'b010000, StOut = 6'b100000
   } state_type;
   state_type state_ff, state_in;

   logic [LW-1:0] clr_ff;
   logic [1:0] mode_ff; logic side_ff; logic [11:0] tick_ff;
   logic [13:0] slot_ff; logic [31:0] shares_ff;
   logic [1:0] wait_ff;

   logic clearing; assign clearing = state_ff == StClear;

   // level memory
   logic lv_we; logic [LW-1:0] lv_wa; plbs_pkg::level_type lv_wd, lv_rd;
   logic [LW-1:0] lv_addr;
   assign lv_addr = {side_ff, tick_ff};
   plbs_ram #(.AddrW(LW), .DataW($bits(plbs_pkg::level_type))) u_level (
      .clock, .wr_en(lv_we), .wr_addr(lv_wa), .wr_data(lv_wd),
      .rd_addr(lv_addr), .rd_data(lv_rd));

   // link memories: separate prev/next, own slot in write phase, neighbors after
   logic np_we, pn_we; logic [13:0] np_wa, pn_wa; logic [KW-1:0] np_wd, pn_wd;
   logic [KW-1:0] next_rd, prev_rd;
   logic [13:0] nx_wa_m, pv_wa_m; logic [KW-1:0] nx_wd_m, pv_wd_m;
   logic nx_we_m, pv_we_m;
   plbs_ram #(.AddrW(14), .DataW(KW)) u_next (
      .clock, .wr_en(nx_we_m), .wr_addr(nx_wa_m), .wr_data(nx_wd_m),
      .rd_addr(slot_ff), .rd_data(next_rd));
   plbs_ram #(.AddrW(14), .DataW(KW)) u_prev (
      .clock, .wr_en(pv_we_m), .wr_addr(pv_wa_m), .wr_data(pv_wd_m),
      .rd_addr(slot_ff), .rd_data(prev_rd));

   logic upd_en, upd_set, scan_start;
   logic bv [2]; logic [11:0] bt [2];
   plbs_best_finder u_best (
      .clock, .reset, .clear(clearing), .clr_addr(clr_ff[plbs_pkg::WordW:0]),
      .upd_en, .upd_side(side_ff), .upd_tick(tick_ff), .upd_set,
      .scan_start, .scan_side(side_ff), .best_valid_ff(bv), .best_tick_ff(bt));

   // result registers
   logic [47:0] tot_ff; logic [14:0] ord_ff, first_ff; logic fault_ff;

   // operation logic
   plbs_pkg::level_type nl;
   logic fault_c, wr_lvl, bitchg;
   always_comb begin
      nl = lv_rd; fault_c = 1'b0; wr_lvl = 1'b0; bitchg = 1'b0; upd_set = 1'b0;
      np_we = 1'b0; np_wa = slot_ff; np_wd = plbs_pkg::NullSlot;
      pn_we = 1'b0; pn_wa = slot_ff; pn_wd = plbs_pkg::NullSlot;
      case (mode_ff)
         plbs_pkg::ModeAdd: begin
            wr_lvl = 1'b1; np_we = 1'b1; pn_we = 1'b1;
            if (lv_rd.count == '0) begin
               nl.head = {1'b0, slot_ff}; bitchg = 1'b1; upd_set = 1'b1;
            end else begin
               pn_wd = lv_rd.tail;
            end
            nl.tail = {1'b0, slot_ff};
            nl.total = (plbs_pkg::TotalMax - lv_rd.total < {16'd0, shares_ff}) ?
                       plbs_pkg::TotalMax : lv_rd.total + {16'd0, shares_ff};
            if (lv_rd.count < KW'(plbs_pkg::PoolSlots)) nl.count = lv_rd.count + 1'b1;
         end
         plbs_pkg::ModeRemove: begin
            if (lv_rd.count == '0) fault_c = 1'b1;
            else begin
               wr_lvl = 1'b1;
               if (lv_rd.head == {1'b0, slot_ff}) nl.head = next_rd;
               if (lv_rd.tail == {1'b0, slot_ff}) nl.tail = prev_rd;
               nl.total = (lv_rd.total < {16'd0, shares_ff}) ? '0 :
                          lv_rd.total - {16'd0, shares_ff};
               nl.count = lv_rd.count - 1'b1;
               if (nl.count == '0) bitchg = 1'b1;
            end
         end
         plbs_pkg::ModeDecrement: begin
            wr_lvl = 1'b1;
            if (lv_rd.total < {16'd0, shares_ff}) begin
               nl.total = '0; fault_c = 1'b1;
            end else nl.total = lv_rd.total - {16'd0, shares_ff};
         end
         default: ;
      endcase
   end

   // neighbor link fixups in the cycle after the write phase
   logic ph2_ff; logic [KW-1:0] p_ff, n_ff; logic [1:0] ph2_mode_ff;
   logic nb_nx_we, nb_pv_we;
   assign nb_nx_we = ph2_ff && (ph2_mode_ff == plbs_pkg::ModeAdd ||
                                ph2_mode_ff == plbs_pkg::ModeRemove) &&
                     (p_ff != plbs_pkg::NullSlot) && !p_ff[KW-1];
   assign nb_pv_we = ph2_ff && ph2_mode_ff == plbs_pkg::ModeRemove &&
                     (n_ff != plbs_pkg::NullSlot) && !n_ff[KW-1];

   logic st_write;
   assign st_write = state_ff == StWrite;
   assign nx_we_m = (st_write && np_we) || nb_nx_we;
   assign nx_wa_m = nb_nx_we ? p_ff[13:0] : np_wa;
   assign nx_wd_m = nb_nx_we ? (ph2_mode_ff == plbs_pkg::ModeAdd ? {1'b0, slot_ff} : n_ff)
                             : np_wd;
   assign pv_we_m = (st_write && pn_we) || nb_pv_we;
   assign pv_wa_m = nb_pv_we ? n_ff[13:0] : pn_wa;
   assign pv_wd_m = nb_pv_we ? p_ff : pn_wd;

   assign lv_we = clearing || (st_write && wr_lvl);
   assign lv_wa = clearing ? clr_ff : lv_addr;
   assign lv_wd = clearing ? '0 : nl;
   assign upd_en = st_write && bitchg;
   assign scan_start = ph2_ff && ph2_mode_ff != plbs_pkg::ModeDecrement &&
                       ph2_mode_ff != plbs_pkg::ModeQuery;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StClear: if (clr_ff == '1) state_in = StIdle;
         StIdle:  if (req.valid) state_in = StRead;
         StRead:  state_in = StWrite;
         StWrite: state_in = StScan;
         StScan:  if (wait_ff == 2'd2) state_in = StOut;
         StOut:   if (rsp.ready) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   assign req.ready = state_ff == StIdle;
   assign rsp.valid = state_ff == StOut;
   assign rsp.best_valid = bv[side_ff];
   assign rsp.best_tick = bt[side_ff];
   assign rsp.level_total = tot_ff;
   assign rsp.level_orders = ord_ff;
   assign rsp.level_first = first_ff;
   assign rsp.level_drained = tot_ff == '0;
   assign rsp.fault = fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear; clr_ff <= '0; ph2_ff <= 1'b0; wait_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_ff <= clr_ff + 1'b1;
         ph2_ff <= st_write;
         if (state_ff == StScan) wait_ff <= wait_ff + 1'b1; else wait_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         mode_ff <= req.mode; side_ff <= req.side; tick_ff <= req.tick;
         slot_ff <= req.slot; shares_ff <= req.shares;
      end
      if (st_write) begin
         ph2_mode_ff <= (mode_ff == plbs_pkg::ModeRemove && lv_rd.count == '0) ?
                        plbs_pkg::ModeQuery : mode_ff;
         p_ff <= (mode_ff == plbs_pkg::ModeAdd) ?
                 ((lv_rd.count == '0) ? plbs_pkg::NullSlot : lv_rd.tail) : prev_rd;
         n_ff <= next_rd;
         tot_ff <= nl.total; ord_ff <= nl.count;
         first_ff <= (nl.count != '0) ? nl.head : plbs_pkg::NullSlot;
         fault_ff <= fault_c;
      end
   end
endmodule
`default_nettype wire
